/* sv/assert_macros.svh */
// assertion helpers, clocked on clk with the async reset arst_n
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define ASSERT_AT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/tng_pkg.sv */
package tng_pkg;

	typedef enum logic [1:0] {
		LAYOUT_ORTHO = 2'd0,
		LAYOUT_ISO   = 2'd1,
		LAYOUT_STAG  = 2'd2,
		LAYOUT_HEX   = 2'd3
	} layout_t;

	typedef enum logic [1:0] {
		REG_LAYOUT = 2'd0,
		REG_DIAG   = 2'd1,
		REG_PARITY = 2'd2,
		REG_AXIS   = 2'd3
	} cfg_reg_t;

	localparam int CFG_DATA_W = 2;

	typedef struct packed {
		logic                  we;
		cfg_reg_t              index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic full;
		logic valid;
	} q_status_t;

	// offset set codes
	localparam logic [2:0] ROW_ORTHO      = 3'd0;
	localparam logic [2:0] ROW_ISO        = 3'd1;
	localparam logic [2:0] ROW_STAG_EVEN  = 3'd2;
	localparam logic [2:0] ROW_STAG_ODD   = 3'd3;
	localparam logic [2:0] ROW_HEX_Y_HIT  = 3'd4;
	localparam logic [2:0] ROW_HEX_Y_MISS = 3'd5;
	localparam logic [2:0] ROW_HEX_X_HIT  = 3'd6;
	localparam logic [2:0] ROW_HEX_X_MISS = 3'd7;

	// index of the final neighbour for each count
	localparam logic [2:0] LAST_OF_4 = 3'd3;
	localparam logic [2:0] LAST_OF_6 = 3'd5;
	localparam logic [2:0] LAST_OF_8 = 3'd7;

	localparam int QUEUE_DEPTH = 2;

	// each entry is {dx, dy}, one octal digit each as 3-bit two's complement
	localparam logic [5:0] OFFS_TAB [8][8] = '{
		'{6'o07, 6'o01, 6'o70, 6'o10, 6'o17, 6'o11, 6'o71, 6'o77},
		'{6'o70, 6'o07, 6'o10, 6'o01, 6'o77, 6'o17, 6'o11, 6'o71},
		'{6'o77, 6'o07, 6'o01, 6'o71, 6'o06, 6'o10, 6'o02, 6'o70},
		'{6'o07, 6'o17, 6'o11, 6'o01, 6'o06, 6'o10, 6'o02, 6'o70},
		'{6'o77, 6'o07, 6'o10, 6'o01, 6'o71, 6'o70, 6'o00, 6'o00},
		'{6'o07, 6'o17, 6'o10, 6'o11, 6'o01, 6'o70, 6'o00, 6'o00},
		'{6'o77, 6'o07, 6'o17, 6'o10, 6'o01, 6'o70, 6'o00, 6'o00},
		'{6'o70, 6'o07, 6'o10, 6'o11, 6'o01, 6'o71, 6'o00, 6'o00}
	};

endpackage

/* sv/tng_ifs.sv */
interface tng_in_if #(
	parameter int W = 16
);
	logic                valid;
	logic                ready;
	logic signed [W-1:0] coord_x;
	logic signed [W-1:0] coord_y;

	modport source(output valid, coord_x, coord_y, input ready);
	modport sink(input valid, coord_x, coord_y, output ready);
endinterface

interface tng_out_if #(
	parameter int W = 16
);
	logic              valid;
	logic              ready;
	logic signed [W:0] nbr_x;
	logic signed [W:0] nbr_y;
	logic [2:0]        nbr_index;
	logic              last_one;

	modport source(output valid, nbr_x, nbr_y, nbr_index, last_one, input ready);
	modport sink(input valid, nbr_x, nbr_y, nbr_index, last_one, output ready);
endinterface

/* sv/tng_front.sv */
module tng_front #(
	parameter int W = 16,
	parameter int ENTRY_W = 2 * W + 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tng_pkg::cfg_wr_t   cfg,
	tng_in_if.sink             req,
	input  tng_pkg::q_status_t q_stat,
	output logic               push,
	output logic [ENTRY_W-1:0] entry
);
	import tng_pkg::*;

	layout_t layout_q;
	logic    diag_q;
	logic    parity_q;
	logic    axis_q;

	logic       x_hit;
	logic       y_hit;
	logic [2:0] row;
	logic [2:0] last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q <= LAYOUT_ORTHO;
			diag_q   <= 1'b0;
			parity_q <= 1'b0;
			axis_q   <= 1'b1;
		end else if (cfg.we) begin
			case (cfg.index)
				REG_LAYOUT: layout_q <= layout_t'(cfg.data);
				REG_DIAG:   diag_q   <= cfg.data[0];
				REG_PARITY: parity_q <= cfg.data[0];
				REG_AXIS:   axis_q   <= cfg.data[0];
				default:    ;
			endcase
		end
	end

	// truncating remainder: negative odd gives -1, which matches neither parity
	assign x_hit = parity_q ? (req.coord_x[0] && !req.coord_x[W-1]) : !req.coord_x[0];
	assign y_hit = parity_q ? (req.coord_y[0] && !req.coord_y[W-1]) : !req.coord_y[0];

	always_comb begin
		case (layout_q)
			LAYOUT_ORTHO: row = ROW_ORTHO;
			LAYOUT_ISO:   row = ROW_ISO;
			LAYOUT_STAG:  row = req.coord_y[0] ? ROW_STAG_ODD : ROW_STAG_EVEN;
			LAYOUT_HEX: begin
				if (axis_q)
					row = y_hit ? ROW_HEX_Y_HIT : ROW_HEX_Y_MISS;
				else
					row = x_hit ? ROW_HEX_X_HIT : ROW_HEX_X_MISS;
			end
			default:      row = ROW_ORTHO;
		endcase
		if (layout_q == LAYOUT_HEX)
			last = LAST_OF_6;
		else
			last = diag_q ? LAST_OF_8 : LAST_OF_4;
	end

	assign req.ready = !q_stat.full;
	assign push      = req.valid && !q_stat.full;
	assign entry     = {req.coord_x, req.coord_y, row, last};

endmodule

/* sv/tng_queue.sv */
`include "assert_macros.svh"

module tng_queue #(
	parameter int ENTRY_W = 38
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [ENTRY_W-1:0] wdata,
	input  logic               pop,
	output logic [ENTRY_W-1:0] rdata,
	output tng_pkg::q_status_t stat
);
	import tng_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [ENTRY_W-1:0] mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wptr_q;
	logic [PTR_W-1:0]   rptr_q;
	logic [CNT_W-1:0]   cnt_q;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	assign rdata      = mem_q[rptr_q];
	assign stat.full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign stat.valid = (cnt_q != '0);

	`ASSERT_AT(a_no_push_when_full, push |-> !stat.full, "word pushed into full queue")
	`ASSERT_AT(a_no_pop_when_empty, pop |-> stat.valid, "word popped from empty queue")
	`ASSERT_AT(a_cnt_bound, cnt_q <= CNT_W'(QUEUE_DEPTH), "queue count past depth")

endmodule

/* sv/tng_back.sv */
`include "assert_macros.svh"

module tng_back #(
	parameter int W = 16,
	parameter int ENTRY_W = 2 * W + 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [ENTRY_W-1:0] head,
	input  tng_pkg::q_status_t q_stat,
	output logic               pop,
	tng_out_if.source          rsp
);
	import tng_pkg::*;

	logic signed [W-1:0] hx;
	logic signed [W-1:0] hy;
	logic [2:0]          hrow;
	logic [2:0]          hlast;
	logic [5:0]          off;
	logic [W:0]          nx;
	logic [W:0]          ny;
	logic                adv;
	logic                at_last;

	logic [2:0] k_q;
	logic       ovalid_q;
	logic [W:0] nbr_x_q;
	logic [W:0] nbr_y_q;
	logic [2:0] nbr_index_q;
	logic       last_one_q;

	assign hx    = head[ENTRY_W-1 -: W];
	assign hy    = head[ENTRY_W-W-1 -: W];
	assign hrow  = head[5:3];
	assign hlast = head[2:0];

	assign off = OFFS_TAB[hrow][k_q];
	assign nx  = {hx[W-1], hx} + {{(W-2){off[5]}}, off[5:3]};
	assign ny  = {hy[W-1], hy} + {{(W-2){off[2]}}, off[2:0]};

	// one neighbour per cycle whenever the queue holds a tile and the output register is free
	assign adv     = q_stat.valid && (!ovalid_q || rsp.ready);
	assign at_last = (k_q == hlast);
	assign pop     = adv && at_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
			k_q      <= '0;
		end else if (adv) begin
			ovalid_q <= 1'b1;
			k_q      <= at_last ? 3'd0 : k_q + 3'd1;
		end else if (rsp.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			nbr_x_q     <= nx;
			nbr_y_q     <= ny;
			nbr_index_q <= k_q;
			last_one_q  <= at_last;
		end
	end

	assign rsp.valid     = ovalid_q;
	assign rsp.nbr_x     = nbr_x_q;
	assign rsp.nbr_y     = nbr_y_q;
	assign rsp.nbr_index = nbr_index_q;
	assign rsp.last_one  = last_one_q;

	`ASSERT_AT(a_head_held_mid_tile, k_q != 3'd0 |-> q_stat.valid, "queue head lost mid tile")
	`ASSERT_AT(a_k_in_range, q_stat.valid |-> k_q <= hlast, "neighbour count past last")
	`ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !ovalid_q && k_q == 3'd0, "not idle in reset")

endmodule

/* sv/tile_neighbour_generator_top.sv */
// tile neighbour generator
// req carries one tile (coord_x, coord_y); rsp returns its neighbours, one word
// each, with nbr_index counting from 0 and last_one set on the final word.
// cfg_we/cfg_index/cfg_wdata write layout, diagonals, stagger parity and stagger
// axis; write them only while no tile is in flight.
// with the back end idle, a tile taken on req is written into the queue and
// its first neighbour is then loaded into the output reg, which drives rsp.
// throughput: a tile gives 4, 6 or 8 neighbours; while a tile is queued and
// rsp does not stall, the back end's offset counter emits one neighbour per
// cycle and starts the next tile's first neighbour in the cycle after the
// previous tile's last.
// the front end classifies each tile into an offset set and count and pushes
// it into a two-word queue, so req keeps taking tiles while rsp is busy.
// reset: configuration returns to orthogonal, no diagonals, even parity, y axis;
// the queue and the output register come up empty.
// stall: when rsp.ready is low the output register holds its word, the back end
// waits, the queue fills and then req.ready drops until space frees up.
module tile_neighbour_generator_top #(
	parameter int COORD_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [1:0] cfg_wdata,
	tng_in_if.sink     req,
	tng_out_if.source  rsp
);
	import tng_pkg::*;

	localparam int ENTRY_W = 2 * COORD_BITS + 6;

	cfg_wr_t            cfg;
	q_status_t          q_stat;
	logic               push;
	logic               pop;
	logic [ENTRY_W-1:0] entry;
	logic [ENTRY_W-1:0] head;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_reg_t'(cfg_index);
	assign cfg.data  = cfg_wdata;

	tng_front #(
		.W       (COORD_BITS),
		.ENTRY_W (ENTRY_W)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.q_stat (q_stat),
		.push   (push),
		.entry  (entry)
	);

	tng_queue #(
		.ENTRY_W (ENTRY_W)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (entry),
		.pop    (pop),
		.rdata  (head),
		.stat   (q_stat)
	);

	tng_back #(
		.W       (COORD_BITS),
		.ENTRY_W (ENTRY_W)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

/* test/tb_tile_neighbour_generator_top.sv */
`timescale 1ns / 100ps

module tb_tile_neighbour_generator_top;
	import tng_pkg::*;

	localparam int COORD_W        = 16;
	localparam int NBR_W          = COORD_W + 1;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PHASES  = 11;
	localparam int PHASE_TILES    = 28;
	localparam int DIR_CFGS       = 6;
	localparam int DIR_PER_CFG    = 4;

	// neighbour offsets per offset set, in emitted order
	localparam int NBR_DX [8][8] = '{
		'{ 0,  0, -1,  1,  1,  1, -1, -1},
		'{-1,  0,  1,  0, -1,  1,  1, -1},
		'{-1,  0,  0, -1,  0,  1,  0, -1},
		'{ 0,  1,  1,  0,  0,  1,  0, -1},
		'{-1,  0,  1,  0, -1, -1,  0,  0},
		'{ 0,  1,  1,  1,  0, -1,  0,  0},
		'{-1,  0,  1,  1,  0, -1,  0,  0},
		'{-1,  0,  1,  1,  0, -1,  0,  0}
	};
	localparam int NBR_DY [8][8] = '{
		'{-1,  1,  0,  0, -1,  1,  1, -1},
		'{ 0, -1,  0,  1, -1, -1,  1,  1},
		'{-1, -1,  1,  1, -2,  0,  2,  0},
		'{-1, -1,  1,  1, -2,  0,  2,  0},
		'{-1, -1,  0,  1,  1,  0,  0,  0},
		'{-1, -1,  0,  1,  1,  0,  0,  0},
		'{-1, -1, -1,  0,  1,  0,  0,  0},
		'{ 0, -1,  0,  1,  1,  1,  0,  0}
	};

	localparam int DIR_X [DIR_CFGS*DIR_PER_CFG] = '{
		-32768, 32767, -32768, 32767, 0, -1, 1, -1,
		0, 1, -1, 2, -3, 5, 32767, -32768,
		-32767, 32766, -2, 3, -5, -32767, -1, 32767
	};
	localparam int DIR_Y [DIR_CFGS*DIR_PER_CFG] = '{
		-32768, 32767, 32767, -32768, 0, -1, 1, 0,
		-1, -1, 1, -2, -5, 3, -32768, 32767,
		-32767, 32766, -3, -4, 2, 32767, -1, -32767
	};

	// first setting is the reset state, no writes
	localparam layout_t DIR_LAYOUT [DIR_CFGS] = '{
		LAYOUT_ORTHO, LAYOUT_ORTHO, LAYOUT_ISO, LAYOUT_STAG, LAYOUT_HEX, LAYOUT_HEX
	};
	localparam logic [1:0] DIR_DIAG [DIR_CFGS]   = '{2'b00, 2'b11, 2'b01, 2'b01, 2'b11, 2'b00};
	localparam logic [1:0] DIR_PARITY [DIR_CFGS] = '{2'b00, 2'b10, 2'b00, 2'b01, 2'b00, 2'b11};
	localparam logic [1:0] DIR_AXIS [DIR_CFGS]   = '{2'b01, 2'b11, 2'b00, 2'b00, 2'b01, 2'b10};

	typedef struct {
		logic signed [NBR_W-1:0] x;
		logic signed [NBR_W-1:0] y;
		logic [2:0]              idx;
		logic                    last;
	} nbr_word_t;

	class nbr_scoreboard;
		layout_t   layout;
		logic      diag;
		logic      parity;
		logic      axis;
		nbr_word_t expected_q[$];
		int        errors;
		int        words_seen;
		int        tiles_by_layout[4];

		function new();
			layout = LAYOUT_ORTHO;
			diag = 1'b0;
			parity = 1'b0;
			axis = 1'b1;
			errors = 0;
			words_seen = 0;
			foreach (tiles_by_layout[i]) tiles_by_layout[i] = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [1:0] d);
			case (idx)
				REG_LAYOUT: layout = layout_t'(d);
				REG_DIAG:   diag = d[0];
				REG_PARITY: parity = d[0];
				REG_AXIS:   axis = d[0];
				default:    ;
			endcase
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// truncating remainder by two: 0 even, 1 positive odd, 2 negative odd
		function int odd_code(logic signed [COORD_W-1:0] v);
			if (!v[0])
				return 0;
			return v[COORD_W-1] ? 2 : 1;
		endfunction

		function void note_tile(logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy);
			int        row;
			int        count;
			bit        hit;
			nbr_word_t w;
			tiles_by_layout[layout]++;
			case (layout)
				LAYOUT_ORTHO: begin
					row = ROW_ORTHO;
					count = diag ? 8 : 4;
				end
				LAYOUT_ISO: begin
					row = ROW_ISO;
					count = diag ? 8 : 4;
				end
				LAYOUT_STAG: begin
					row = cy[0] ? ROW_STAG_ODD : ROW_STAG_EVEN;
					count = diag ? 8 : 4;
				end
				default: begin
					hit = ((axis ? odd_code(cy) : odd_code(cx)) == int'(parity));
					if (axis)
						row = hit ? ROW_HEX_Y_HIT : ROW_HEX_Y_MISS;
					else
						row = hit ? ROW_HEX_X_HIT : ROW_HEX_X_MISS;
					count = 6;
				end
			endcase
			for (int k = 0; k < count; k++) begin
				w.x = NBR_W'(int'(cx) + NBR_DX[row][k]);
				w.y = NBR_W'(int'(cy) + NBR_DY[row][k]);
				w.idx = 3'(k);
				w.last = (k == count - 1);
				expected_q.insert(expected_q.size(), w);
			end
		endfunction

		task report_mismatch(string what);
			errors++;
			$display("mismatch at %0t: %s", $time, what);
		endtask

		task check_word(logic signed [NBR_W-1:0] x, logic signed [NBR_W-1:0] y,
				logic [2:0] idx, logic last);
			nbr_word_t w;
			words_seen++;
			if (expected_q.size() == 0) begin
				report_mismatch($sformatf("unexpected word (%0d,%0d) idx %0d last %0b",
					x, y, idx, last));
				return;
			end
			w = expected_q.pop_front();
			if (x !== w.x || y !== w.y || idx !== w.idx || last !== w.last)
				report_mismatch($sformatf("got (%0d,%0d) idx %0d last %0b, want (%0d,%0d) idx %0d last %0b",
					x, y, idx, last, w.x, w.y, w.idx, w.last));
		endtask
	endclass

	logic       clk;
	logic       arst_n;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [1:0] cfg_wdata;

	tng_in_if  #(.W(COORD_W)) req_if ();
	tng_out_if #(.W(COORD_W)) rsp_if ();

	tile_neighbour_generator_top #(
		.COORD_BITS(COORD_W)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req      (req_if),
		.rsp      (rsp_if)
	);

	nbr_scoreboard sb;
	int            settings_run;
	int            idle_cycles;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// accepted words, sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_if.valid && req_if.ready)
				sb.note_tile(req_if.coord_x, req_if.coord_y);
			if (rsp_if.valid && rsp_if.ready)
				sb.check_word(rsp_if.nbr_x, rsp_if.nbr_y, rsp_if.nbr_index, rsp_if.last_one);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
				$display("** tile_neighbour_generator_top: FAILED **");
				$finish;
			end
		end
	end

	// receiver: modes of always ready, random ready, and occasional long stalls
	initial begin : rx_stall
		int mode;
		int mode_left;
		int stall_left;
		logic rdy;
		mode = 0;
		mode_left = 0;
		stall_left = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 80);
			end else begin
				mode_left = mode_left - 1;
			end
			case (mode)
				0: rdy = 1'b1;
				1: rdy = ($urandom_range(0, 9) < 7);
				default: begin
					if (stall_left > 0) begin
						stall_left = stall_left - 1;
						rdy = 1'b0;
					end else if ($urandom_range(0, 7) == 0) begin
						stall_left = $urandom_range(1, 10);
						rdy = 1'b0;
					end else begin
						rdy = 1'b1;
					end
				end
			endcase
			rsp_if.ready <= rdy;
		end
	end

	task write_reg(cfg_reg_t idx, logic [1:0] d);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= d;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, d);
	endtask

	task apply_setting(layout_t lay, logic [1:0] d, logic [1:0] p, logic [1:0] a);
		write_reg(REG_LAYOUT, 2'(lay));
		write_reg(REG_DIAG, d);
		write_reg(REG_PARITY, p);
		write_reg(REG_AXIS, a);
		settings_run++;
	endtask

	// valid stays high after acceptance until the next falling edge
	task send_tile(logic signed [COORD_W-1:0] cx, logic signed [COORD_W-1:0] cy);
		@(negedge clk);
		req_if.valid <= 1'b1;
		req_if.coord_x <= cx;
		req_if.coord_y <= cy;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
	endtask

	task pause_input(int n);
		@(negedge clk);
		req_if.valid <= 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task wait_drain();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	function logic signed [COORD_W-1:0] rand_coord();
		int pick;
		pick = $urandom_range(0, 5);
		case (pick)
			0, 1: return COORD_W'($urandom);
			2, 3: return COORD_W'(int'($urandom_range(0, 15)) - 8);
			4: begin
				case ($urandom_range(0, 3))
					0: return COORD_W'(-32768);
					1: return COORD_W'(-32767);
					2: return COORD_W'(32766);
					default: return COORD_W'(32767);
				endcase
			end
			default: return COORD_W'(int'($urandom_range(0, 255)) - 128);
		endcase
	endfunction

	initial begin : stimulus
		int      sent;
		int      burst;
		bit      no_gap;
		layout_t lay;
		sb = new();
		settings_run = 0;
		idle_cycles = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_LAYOUT;
		cfg_wdata = 2'b00;
		req_if.valid = 1'b0;
		req_if.coord_x = '0;
		req_if.coord_y = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed corners under each layout, the first one at reset values
		for (int c = 0; c < DIR_CFGS; c++) begin
			if (c > 0) begin
				wait_drain();
				apply_setting(DIR_LAYOUT[c], DIR_DIAG[c], DIR_PARITY[c], DIR_AXIS[c]);
			end
			for (int k = 0; k < DIR_PER_CFG; k++) begin
				send_tile(COORD_W'(DIR_X[c*DIR_PER_CFG+k]), COORD_W'(DIR_Y[c*DIR_PER_CFG+k]));
				if ($urandom_range(0, 2) == 0)
					pause_input($urandom_range(1, 4));
			end
		end

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			wait_drain();
			if (p < 8)
				lay = layout_t'(p % 4);
			else
				lay = layout_t'($urandom_range(0, 3));
			apply_setting(lay, (p < 8) ? 2'(p / 4) : 2'($urandom_range(0, 3)),
				2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)));
			no_gap = ($urandom_range(0, 3) == 0);
			sent = 0;
			while (sent < PHASE_TILES) begin
				burst = $urandom_range(1, 12);
				for (int b = 0; b < burst && sent < PHASE_TILES; b++) begin
					send_tile(rand_coord(), rand_coord());
					sent++;
					// hold off until the block has emptied
					if ((p == 2 && sent == PHASE_TILES / 2) || $urandom_range(0, 39) == 0)
						wait_drain();
				end
				if (!no_gap)
					pause_input($urandom_range(1, 6));
			end
		end

		wait_drain();
		repeat (8) @(posedge clk);
		if (sb.pending() != 0)
			sb.report_mismatch($sformatf("%0d neighbour words never came", sb.pending()));

		$display("tiles: ortho %0d, iso %0d, staggered %0d, hex %0d; %0d neighbour words checked",
			sb.tiles_by_layout[LAYOUT_ORTHO], sb.tiles_by_layout[LAYOUT_ISO],
			sb.tiles_by_layout[LAYOUT_STAG], sb.tiles_by_layout[LAYOUT_HEX], sb.words_seen);
		$display("%0d register settings, with sender gaps and receiver stalls; %0d mismatches",
			settings_run, sb.errors);
		if (sb.errors == 0)
			$display("** tile_neighbour_generator_top: PASSED **");
		else
			$display("** tile_neighbour_generator_top: FAILED **");
		$finish;
	end

endmodule
